// ===== rtl/core/rtis_pkg.sv =====
// Package for the rest triangle inverse setup pipeline.
// Holds fixed widths, constants, the divider lane type, its start and its one-bit step.
// No dependencies.
package rtis_pkg;

    // Edge vector component: difference of two Q8.16 values
    localparam int EW = 25;
    // Edge product and determinant widths
    localparam int PW = 2 * EW;
    localparam int DETW = PW + 1;
    // Divisor magnitude width
    localparam int DW = PW;
    // Numerator magnitude width
    localparam int NW = EW - 1;
    // Quotient bits (|q| < 2^44)
    localparam int QBITS = 45;
    // Number of inverse entries
    localparam int NLANES = 4;

    // 1e-6 in Q32
    localparam logic signed [DETW-1:0] DET_FLOOR = DETW'(4295);
    // 1e6 in Q23.8
    localparam logic [30:0] MAT_FALLBACK = 31'd256000000;

    // Origin slot codes
    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;
    localparam logic [1:0] SLOT_C = 2'd2;

    // One divider lane: partial remainder, quotient/dividend shift word, sign
    typedef struct packed {
        logic [DW-1:0]    rem;
        logic [QBITS-1:0] qf;
        logic             neg;
    } div_lane_t;

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic div_lane_t div_step(div_lane_t l, logic [DW-1:0] d);
        logic [DW:0] r2;
        logic [DW:0] diff;
        div_lane_t   o;
        r2   = {l.rem, l.qf[QBITS-1]};
        diff = r2 - {1'b0, d};
        o.neg = l.neg;
        if (!diff[DW]) begin
            o.rem = diff[DW-1:0];
            o.qf  = {l.qf[QBITS-2:0], 1'b1};
        end else begin
            o.rem = r2[DW-1:0];
            o.qf  = {l.qf[QBITS-2:0], 1'b0};
        end
        return o;
    endfunction

    // Start a lane from a signed numerator: dividend is |num| * 2^32
    function automatic div_lane_t div_init(logic signed [EW-1:0] num, logic det_neg);
        logic [EW-1:0] mag;
        div_lane_t     o;
        mag   = num[EW-1] ? (~num + 1'b1) : num;
        o.rem = DW'(mag[NW-1:13]);
        o.qf  = {mag[12:0], 32'd0};
        o.neg = num[EW-1] ^ det_neg;
        return o;
    endfunction

endpackage

// ===== rtl/core/rest_triangle_inverse_setup.sv =====
// Registers in order: edge matrix, cross products, determinant, divider chain, output.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// The divider is a chain of 45 one-bit restoring stages, four lanes wide.
// Reset (aresetn low, synchronous) clears all valid bits and default_material.
// Top level: origin selection, edge matrix, determinant, pipelined inverse divider.
// Depends on rtis_pkg.
module rest_triangle_inverse_setup #(
    parameter int INDEX_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [30:0]            cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [INDEX_BITS-1:0]  s_vertex_index_a,
    input  logic [INDEX_BITS-1:0]  s_vertex_index_b,
    input  logic [INDEX_BITS-1:0]  s_vertex_index_c,
    input  logic signed [23:0]     s_pos_a_x,
    input  logic signed [23:0]     s_pos_a_y,
    input  logic signed [23:0]     s_pos_b_x,
    input  logic signed [23:0]     s_pos_b_y,
    input  logic signed [23:0]     s_pos_c_x,
    input  logic signed [23:0]     s_pos_c_y,
    input  logic signed [31:0]     s_material_value,
    input  logic                   s_material_present,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [INDEX_BITS-1:0]  m_origin_index,
    output logic [INDEX_BITS-1:0]  m_first_index,
    output logic [INDEX_BITS-1:0]  m_second_index,
    output logic signed [47:0]     m_inverse_00,
    output logic signed [47:0]     m_inverse_01,
    output logic signed [47:0]     m_inverse_10,
    output logic signed [47:0]     m_inverse_11,
    output logic [32:0]            m_half_area,
    output logic [30:0]            m_material_out
);
    import rtis_pkg::*;

    // Fields carried alongside the arithmetic
    typedef struct packed {
        logic [INDEX_BITS-1:0] idx_o;
        logic [INDEX_BITS-1:0] idx_f;
        logic [INDEX_BITS-1:0] idx_s;
        logic [30:0]           mat;
    } side_t;

    typedef struct packed {
        side_t                 side;
        logic [32:0]           area;
        logic [DW-1:0]         d;
        div_lane_t [NLANES-1:0] lane;
    } div_stage_t;

    logic        en;
    logic [30:0] default_material_reg;

    // Stage 1 registers
    logic                   v1_reg;
    side_t                  side1_reg;
    logic signed [EW-1:0]   m00_1_reg, m10_1_reg, m01_1_reg, m11_1_reg;
    // Stage 2 registers
    logic                   v2_reg;
    side_t                  side2_reg;
    logic signed [EW-1:0]   m00_2_reg, m10_2_reg, m01_2_reg, m11_2_reg;
    logic signed [PW-1:0]   pa_2_reg, pb_2_reg;
    // Stage 3 registers
    logic                   v3_reg;
    side_t                  side3_reg;
    logic signed [EW-1:0]   m00_3_reg, m10_3_reg, m01_3_reg, m11_3_reg;
    logic signed [DETW-1:0] det_3_reg;
    // Divider stages
    logic                   dv_v_reg [0:QBITS];
    div_stage_t             dv_reg   [0:QBITS];
    // Output register
    logic                   m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    // Hold the default material register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_material_reg <= '0;
        end else if (cfg_wr_en) begin
            default_material_reg <= cfg_wr_data;
        end
    end

    // Origin choice: strictly more lower-left
    function automatic logic lower_left(logic signed [23:0] cx, logic signed [23:0] cy,
                                        logic signed [23:0] ux, logic signed [23:0] uy);
        logic signed [24:0] cs;
        logic signed [24:0] us;
        cs = 25'(cx) + 25'(cy);
        us = 25'(ux) + 25'(uy);
        if (cs != us) begin
            return cs < us;
        end else if (cy != uy) begin
            return cy < uy;
        end
        return cx < ux;
    endfunction

    // Apply the sign to a quotient magnitude
    function automatic logic signed [47:0] signed_q(div_lane_t l);
        logic [47:0] q;
        q = 48'(l.qf);
        return l.neg ? -q : q;
    endfunction

    logic [1:0]            org_next;
    logic signed [23:0]    ox, oy, fx, fy, sx, sy;
    side_t                 side1_next;

    // Pick origin, rotate slots, select material
    always_comb begin
        org_next = SLOT_A;
        if (lower_left(s_pos_b_x, s_pos_b_y, s_pos_a_x, s_pos_a_y)) begin
            org_next = SLOT_B;
        end
        case (org_next)
            SLOT_B: begin
                if (lower_left(s_pos_c_x, s_pos_c_y, s_pos_b_x, s_pos_b_y)) begin
                    org_next = SLOT_C;
                end
            end
            default: begin
                if (lower_left(s_pos_c_x, s_pos_c_y, s_pos_a_x, s_pos_a_y)) begin
                    org_next = SLOT_C;
                end
            end
        endcase
        case (org_next)
            SLOT_B: begin
                ox = s_pos_b_x; oy = s_pos_b_y;
                fx = s_pos_c_x; fy = s_pos_c_y;
                sx = s_pos_a_x; sy = s_pos_a_y;
                side1_next.idx_o = s_vertex_index_b;
                side1_next.idx_f = s_vertex_index_c;
                side1_next.idx_s = s_vertex_index_a;
            end
            SLOT_C: begin
                ox = s_pos_c_x; oy = s_pos_c_y;
                fx = s_pos_a_x; fy = s_pos_a_y;
                sx = s_pos_b_x; sy = s_pos_b_y;
                side1_next.idx_o = s_vertex_index_c;
                side1_next.idx_f = s_vertex_index_a;
                side1_next.idx_s = s_vertex_index_b;
            end
            default: begin
                ox = s_pos_a_x; oy = s_pos_a_y;
                fx = s_pos_b_x; fy = s_pos_b_y;
                sx = s_pos_c_x; sy = s_pos_c_y;
                side1_next.idx_o = s_vertex_index_a;
                side1_next.idx_f = s_vertex_index_b;
                side1_next.idx_s = s_vertex_index_c;
            end
        endcase
        if (!s_material_present) begin
            side1_next.mat = default_material_reg;
        end else if (s_material_value[31] || s_material_value == 32'sd0) begin
            side1_next.mat = MAT_FALLBACK;
        end else begin
            side1_next.mat = s_material_value[30:0];
        end
    end

    // Valid bits advance with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= QBITS; k++) begin
                dv_v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            dv_v_reg[0] <= v3_reg;
            for (int k = 1; k <= QBITS; k++) begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
            m_valid_reg <= dv_v_reg[QBITS];
        end
    end

    logic signed [DETW-1:0] det_raw;
    logic signed [DETW-1:0] det_next;
    logic [DETW-1:0]        adet;
    div_stage_t             dv0_next;

    // Force tiny determinants away from zero
    always_comb begin
        det_raw = DETW'(pa_2_reg) - DETW'(pb_2_reg);
        det_next = det_raw;
        if (det_raw > -DET_FLOOR && det_raw < DET_FLOOR) begin
            det_next = det_raw[DETW-1] ? -DET_FLOOR : DET_FLOOR;
        end
    end

    // Take magnitude, area, and start the four divider lanes
    always_comb begin
        adet = det_3_reg[DETW-1] ? (~det_3_reg + 1'b1) : det_3_reg;
        dv0_next.side    = side3_reg;
        dv0_next.d       = adet[DW-1:0];
        dv0_next.area    = 33'(adet >> 17);
        dv0_next.lane[0] = div_init(m11_3_reg, det_3_reg[DETW-1]);
        dv0_next.lane[1] = div_init(-m01_3_reg, det_3_reg[DETW-1]);
        dv0_next.lane[2] = div_init(-m10_3_reg, det_3_reg[DETW-1]);
        dv0_next.lane[3] = div_init(m00_3_reg, det_3_reg[DETW-1]);
    end

    // Payload pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            // Edge matrix
            side1_reg <= side1_next;
            m00_1_reg <= EW'(fx) - EW'(ox);
            m10_1_reg <= EW'(fy) - EW'(oy);
            m01_1_reg <= EW'(sx) - EW'(ox);
            m11_1_reg <= EW'(sy) - EW'(oy);
            // Cross products
            side2_reg <= side1_reg;
            m00_2_reg <= m00_1_reg;
            m10_2_reg <= m10_1_reg;
            m01_2_reg <= m01_1_reg;
            m11_2_reg <= m11_1_reg;
            pa_2_reg  <= PW'(m00_1_reg) * PW'(m11_1_reg);
            pb_2_reg  <= PW'(m01_1_reg) * PW'(m10_1_reg);
            // Determinant
            side3_reg <= side2_reg;
            m00_3_reg <= m00_2_reg;
            m10_3_reg <= m10_2_reg;
            m01_3_reg <= m01_2_reg;
            m11_3_reg <= m11_2_reg;
            det_3_reg <= det_next;
            // Divider chain
            dv_reg[0] <= dv0_next;
            for (int k = 1; k <= QBITS; k++) begin
                dv_reg[k].side <= dv_reg[k-1].side;
                dv_reg[k].area <= dv_reg[k-1].area;
                dv_reg[k].d    <= dv_reg[k-1].d;
                for (int j = 0; j < NLANES; j++) begin
                    dv_reg[k].lane[j] <= div_step(dv_reg[k-1].lane[j], dv_reg[k-1].d);
                end
            end
            // Output: apply signs
            m_origin_index <= dv_reg[QBITS].side.idx_o;
            m_first_index  <= dv_reg[QBITS].side.idx_f;
            m_second_index <= dv_reg[QBITS].side.idx_s;
            m_material_out <= dv_reg[QBITS].side.mat;
            m_half_area    <= dv_reg[QBITS].area;
            m_inverse_00   <= signed_q(dv_reg[QBITS].lane[0]);
            m_inverse_01   <= signed_q(dv_reg[QBITS].lane[1]);
            m_inverse_10   <= signed_q(dv_reg[QBITS].lane[2]);
            m_inverse_11   <= signed_q(dv_reg[QBITS].lane[3]);
        end
    end

endmodule

// ===== rtl/core/rtis_checker.sv =====
// Port-level checker for rest_triangle_inverse_setup, bound to the top level.
// Depends only on the top level's ports.
module rtis_checker #(
    parameter int INDEX_BITS = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [INDEX_BITS-1:0] m_origin_index,
    input logic signed [47:0]    m_inverse_00,
    input logic [32:0]           m_half_area
);

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input is taken whenever the output slot is free or draining
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not track output stall");

    // Stalled item holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_origin_index)
            && $stable(m_inverse_00) && $stable(m_half_area))
        else $error("stalled item changed");

endmodule

bind rest_triangle_inverse_setup rtis_checker #(.INDEX_BITS(INDEX_BITS)) u_rtis_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_origin_index (m_origin_index),
    .m_inverse_00   (m_inverse_00),
    .m_half_area    (m_half_area)
);

// ===== tb/sv/rest_triangle_inverse_setup_tb.sv =====
// Self-checking testbench for rest_triangle_inverse_setup: directed and random triangles,
// bursty input, stalling output, configuration changes between drained phases.
// Depends on rtis_pkg and the rest_triangle_inverse_setup RTL.
`timescale 1ns / 1ps

module rest_triangle_inverse_setup_tb;
    import rtis_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;
    localparam longint MAX48_L    = 64'sd140737488355327;
    localparam longint MIN48_L    = -64'sd140737488355328;
    localparam longint MAX33_L    = 64'sd8589934591;

    typedef struct {
        logic [15:0]        ia, ib, ic;
        logic signed [23:0] ax, ay, bx, by, cx, cy;
        logic signed [31:0] mat;
        logic               present;
    } triangle_t;

    typedef struct {
        logic [15:0]        origin, first, second;
        logic signed [47:0] i00, i01, i10, i11;
        logic [32:0]        area;
        logic [30:0]        mat;
    } rest_shape_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [30:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_vertex_index_a = '0, s_vertex_index_b = '0, s_vertex_index_c = '0;
    logic signed [23:0] s_pos_a_x = '0, s_pos_a_y = '0, s_pos_b_x = '0;
    logic signed [23:0] s_pos_b_y = '0, s_pos_c_x = '0, s_pos_c_y = '0;
    logic signed [31:0] s_material_value = '0;
    logic s_material_present = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_origin_index, m_first_index, m_second_index;
    logic signed [47:0] m_inverse_00, m_inverse_01, m_inverse_10, m_inverse_11;
    logic [32:0] m_half_area;
    logic [30:0] m_material_out;

    rest_triangle_inverse_setup #(.INDEX_BITS(16)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_vertex_index_a(s_vertex_index_a), .s_vertex_index_b(s_vertex_index_b),
        .s_vertex_index_c(s_vertex_index_c),
        .s_pos_a_x(s_pos_a_x), .s_pos_a_y(s_pos_a_y),
        .s_pos_b_x(s_pos_b_x), .s_pos_b_y(s_pos_b_y),
        .s_pos_c_x(s_pos_c_x), .s_pos_c_y(s_pos_c_y),
        .s_material_value(s_material_value), .s_material_present(s_material_present),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_origin_index(m_origin_index), .m_first_index(m_first_index),
        .m_second_index(m_second_index),
        .m_inverse_00(m_inverse_00), .m_inverse_01(m_inverse_01),
        .m_inverse_10(m_inverse_10), .m_inverse_11(m_inverse_11),
        .m_half_area(m_half_area), .m_material_out(m_material_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    rest_shape_t shape_queue[$];
    logic [30:0] default_material = '0;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          hold_requests = 0;

    // Strictly more lower-left: smaller x+y, then smaller y, then smaller x
    function automatic bit is_lower_left(longint cx, longint cy, longint ux, longint uy);
        if (cx + cy != ux + uy) return (cx + cy) < (ux + uy);
        if (cy != uy) return cy < uy;
        return cx < ux;
    endfunction

    function automatic logic signed [47:0] inverse_entry(longint num, longint det);
        longint q;
        q = (num * 64'sd4294967296) / det;
        if (q > MAX48_L) q = MAX48_L;
        if (q < MIN48_L) q = MIN48_L;
        return q[47:0];
    endfunction

    function automatic rest_shape_t predict_shape(triangle_t t, logic [30:0] dflt);
        longint px[3], py[3], m00, m10, m01, m11, det, adet, area, floor_l;
        logic [15:0] idx[3];
        int o, f, s;
        rest_shape_t r;
        px[0] = t.ax; py[0] = t.ay; px[1] = t.bx; py[1] = t.by; px[2] = t.cx; py[2] = t.cy;
        idx[0] = t.ia; idx[1] = t.ib; idx[2] = t.ic;
        o = 0;
        for (int k = 1; k < 3; k++)
            if (is_lower_left(px[k], py[k], px[o], py[o])) o = k;
        f = (o + 1) % 3;
        s = (o + 2) % 3;
        m00 = px[f] - px[o];
        m10 = py[f] - py[o];
        m01 = px[s] - px[o];
        m11 = py[s] - py[o];
        det = m00 * m11 - m01 * m10;
        floor_l = longint'(DET_FLOOR);
        // Push tiny determinants away from zero, zero counts as positive
        if (det > -floor_l && det < floor_l) det = (det < 0) ? -floor_l : floor_l;
        adet = (det < 0) ? -det : det;
        area = adet >>> 17;
        if (area > MAX33_L) area = MAX33_L;
        r.origin = idx[o];
        r.first  = idx[f];
        r.second = idx[s];
        r.i00 = inverse_entry(m11, det);
        r.i01 = inverse_entry(-m01, det);
        r.i10 = inverse_entry(-m10, det);
        r.i11 = inverse_entry(m00, det);
        r.area = area[32:0];
        if (t.present) r.mat = (t.mat <= 0) ? MAT_FALLBACK : t.mat[30:0];
        else r.mat = dflt;
        return r;
    endfunction

    // Check results, record accepted items, watch for a hang
    always @(posedge aclk) begin
        rest_shape_t e;
        triangle_t t;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (shape_queue.size() == 0) begin
                    $error("result with no item pending");
                    error_count++;
                end else begin
                    e = shape_queue.pop_front();
                    if (m_origin_index !== e.origin) begin
                        $error("origin_index exp %0d got %0d", e.origin, m_origin_index);
                        error_count++;
                    end
                    if (m_first_index !== e.first) begin
                        $error("first_index exp %0d got %0d", e.first, m_first_index);
                        error_count++;
                    end
                    if (m_second_index !== e.second) begin
                        $error("second_index exp %0d got %0d", e.second, m_second_index);
                        error_count++;
                    end
                    if (m_inverse_00 !== e.i00) begin
                        $error("inverse_00 exp %0d got %0d", e.i00, m_inverse_00);
                        error_count++;
                    end
                    if (m_inverse_01 !== e.i01) begin
                        $error("inverse_01 exp %0d got %0d", e.i01, m_inverse_01);
                        error_count++;
                    end
                    if (m_inverse_10 !== e.i10) begin
                        $error("inverse_10 exp %0d got %0d", e.i10, m_inverse_10);
                        error_count++;
                    end
                    if (m_inverse_11 !== e.i11) begin
                        $error("inverse_11 exp %0d got %0d", e.i11, m_inverse_11);
                        error_count++;
                    end
                    if (m_half_area !== e.area) begin
                        $error("half_area exp %0d got %0d", e.area, m_half_area);
                        error_count++;
                    end
                    if (m_material_out !== e.mat) begin
                        $error("material_out exp %0d got %0d", e.mat, m_material_out);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                t.ia = s_vertex_index_a; t.ib = s_vertex_index_b; t.ic = s_vertex_index_c;
                t.ax = s_pos_a_x; t.ay = s_pos_a_y; t.bx = s_pos_b_x;
                t.by = s_pos_b_y; t.cx = s_pos_c_x; t.cy = s_pos_c_y;
                t.mat = s_material_value; t.present = s_material_present;
                shape_queue.insert(shape_queue.size(), predict_shape(t, default_material));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Output stall pattern; a long hold-off runs when requested
    always @(negedge aclk) begin
        int hold_left, seen_requests, mode, mode_left;
        if (hold_requests != seen_requests) begin
            seen_requests = hold_requests;
            hold_left = 400;
        end
        if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Offer one item in bursts with random gaps; returns at a falling edge after accept
    task automatic send_item(triangle_t t);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_vertex_index_a = t.ia; s_vertex_index_b = t.ib; s_vertex_index_c = t.ic;
        s_pos_a_x = t.ax; s_pos_a_y = t.ay; s_pos_b_x = t.bx;
        s_pos_b_y = t.by; s_pos_c_x = t.cx; s_pos_c_y = t.cy;
        s_material_value = t.mat; s_material_present = t.present;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every pending result, then let the pipe empty
    task automatic drain;
        s_valid = 1'b0;
        burst_left = 0;
        while (shape_queue.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_default(logic [30:0] v);
        drain();
        cfg_wr_data = v;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        default_material = v;
        cfg_wr_en = 1'b0;
    endtask

    function automatic triangle_t make_tri(longint ax, longint ay, longint bx, longint by,
                                           longint cx, longint cy, longint mat, bit present);
        triangle_t t;
        t.ia = 16'd10; t.ib = 16'd20; t.ic = 16'd30;
        t.ax = 24'(ax); t.ay = 24'(ay); t.bx = 24'(bx);
        t.by = 24'(by); t.cx = 24'(cx); t.cy = 24'(cy);
        t.mat = 32'(mat); t.present = present;
        return t;
    endfunction

    function automatic logic signed [23:0] rand_coord(int kind);
        logic [31:0] r;
        r = $urandom;
        case (kind)
            0: return r[23:0];
            1: return 24'(int'($urandom_range(0, 128)) - 64);
            default: return (r[0] ? 24'sh7FFFFF : 24'sh800000) ^ 24'(r[4:1]);
        endcase
    endfunction

    function automatic triangle_t random_tri();
        triangle_t t;
        int kind;
        logic signed [23:0] d;
        kind = $urandom_range(0, 9);
        t.ia = 16'($urandom); t.ib = 16'($urandom); t.ic = 16'($urandom);
        if (kind < 5) begin
            t.ax = rand_coord(0); t.ay = rand_coord(0); t.bx = rand_coord(0);
            t.by = rand_coord(0); t.cx = rand_coord(0); t.cy = rand_coord(0);
        end else if (kind < 7) begin
            // small triangle near a random point: tiny determinants
            d = rand_coord(0);
            t.ax = d + rand_coord(1); t.ay = d + rand_coord(1); t.bx = d + rand_coord(1);
            t.by = d + rand_coord(1); t.cx = d + rand_coord(1); t.cy = d + rand_coord(1);
        end else if (kind < 9) begin
            // tie on x+y between vertices, random third
            t.ax = rand_coord(1); t.ay = rand_coord(1);
            d = rand_coord(1);
            t.bx = t.ax + d; t.by = t.ay - d;
            t.cx = ($urandom_range(0, 1) == 1) ? t.ax : rand_coord(0);
            t.cy = ($urandom_range(0, 1) == 1) ? t.ay : rand_coord(0);
        end else begin
            t.ax = rand_coord(2); t.ay = rand_coord(2); t.bx = rand_coord(2);
            t.by = rand_coord(2); t.cx = rand_coord(2); t.cy = rand_coord(2);
        end
        case ($urandom_range(0, 5))
            0: t.mat = 32'sd0;
            1: t.mat = -32'sd1 - 32'($urandom_range(0, 100));
            2: t.mat = 32'sh80000000;
            default: t.mat = $urandom;
        endcase
        t.present = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // Default register at reset value, no material entries
    task automatic test_reset_default;
        send_item(make_tri(0, 0, 65536, 0, 0, 65536, 5, 1'b0));
        send_item(make_tri(100, 0, 0, 100, 0, 0, 0, 1'b0));
    endtask

    task automatic test_directed;
        triangle_t t;
        write_default(31'h7FFFFFFF);
        // identical vertices: zero determinant forced positive
        send_item(make_tri(5, 5, 5, 5, 5, 5, 0, 1'b1));
        // collinear
        send_item(make_tri(0, 0, 100, 100, 200, 200, -1, 1'b1));
        // tiny negative and tiny positive determinant
        send_item(make_tri(0, 0, 0, 1, 1, 0, 7, 1'b1));
        send_item(make_tri(0, 0, 1, 0, 0, 1, 32'sh7FFFFFFF, 1'b1));
        // full ties keep the earlier slot, x+y ties go by y then x
        send_item(make_tri(3, 3, 3, 3, 9, 9, 32'sh80000000, 1'b1));
        send_item(make_tri(9, 9, 4, 2, 2, 4, 1, 1'b0));
        send_item(make_tri(9, 9, 2, 4, 4, 2, 1, 1'b1));
        // position extremes: largest determinant and large inverse entries
        send_item(make_tri(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607, 3, 1'b1));
        send_item(make_tri(-8388608, -8388608, -8388608, 8388607, 8388607, -8388608, 3, 1'b0));
        send_item(make_tri(8388607, 8388607, 8388607, 8388607, -8388608, -8388608, 0, 1'b1));
        send_item(make_tri(-8388608, 8388607, 8388607, -8388608, 0, 0, 256, 1'b1));
        // long thin triangle: edge entries near the full position range
        send_item(make_tri(-8388608, 0, 8388607, 1, 8388607, 0, 256, 1'b1));
        // index extremes, with the origin in slot B and then in slot C
        t = make_tri(10, 10, 0, 0, 5, 20, 42, 1'b1);
        t.ia = 16'hFFFF; t.ib = 16'h0000; t.ic = 16'hAAAA;
        send_item(t);
        t = make_tri(10, 10, 5, 20, 0, 0, 42, 1'b0);
        t.ia = 16'h0000; t.ib = 16'hFFFF; t.ic = 16'h5555;
        send_item(t);
        write_default(31'd0);
        send_item(make_tri(0, 0, 65536, 0, 0, 65536, 0, 1'b0));
    endtask

    task automatic test_random(int count, logic [30:0] dflt);
        write_default(dflt);
        repeat (count) send_item(random_tri());
    endtask

    // Hold the output off long enough to fill the pipe and stall the input
    task automatic test_backpressure;
        drain();
        hold_requests++;
        repeat (200) send_item(random_tri());
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_default();
        test_directed();
        test_random(450, 31'h7FFFFFFF);
        test_backpressure();
        test_random(450, 31'(($urandom)));
        test_random(450, 31'd1);
        test_random(300, 31'd0);
        drain();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rtis_pkg.sv
rtl/core/rest_triangle_inverse_setup.sv
rtl/core/rtis_checker.sv
tb/sv/rest_triangle_inverse_setup_tb.sv
